// ----- src/pbrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// pbrgb_pkg
// Shared types and constants of the PackBits RGB strip pixel decoder.
// ----------------------------------------------------------------------------
package pbrgb_pkg;

    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LINES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_ON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PACKBITS_ON  = 3'd4;

    localparam logic [CFG_W-1:0] LINE_PIXELS_RST = 14'd1;
    localparam logic [CFG_W-1:0] FRAME_LINES_RST = 14'd1;
    localparam logic [CFG_W-1:0] STRIP_LINES_RST = 14'd8192;

    localparam logic [7:0] HDR_NOP = 8'h80;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REPEAT = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] line_pixels;
        logic [CFG_W-1:0] frame_lines;
        logic [CFG_W-1:0] strip_lines;
        logic             predictor_on;
        logic             packbits_on;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic rep_step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic starts_repeat;
        logic step_emits;
        logic rep_final;
    } status_t;

endpackage

// ----- src/pbrgb_byte_if.sv -----
// ----------------------------------------------------------------------------
// pbrgb_byte_if
// Raw strip byte channel.
// ----------------------------------------------------------------------------
interface pbrgb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- src/pbrgb_pixel_if.sv -----
// ----------------------------------------------------------------------------
// pbrgb_pixel_if
// Decoded pixel channel.
// ----------------------------------------------------------------------------
interface pbrgb_pixel_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_column;
    logic [12:0] pixel_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        strip_end;
    logic        frame_end;
    logic        last_of_item;

    modport source (output valid, output pixel_column, output pixel_row, output red,
                    output green, output blue, output strip_end, output frame_end,
                    output last_of_item, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, input red,
                    input green, input blue, input strip_end, input frame_end,
                    input last_of_item, output ready);
endinterface

// ----- src/packbits_rgb_strip_pixel_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// packbits_rgb_strip_pixel_decoder_unit
// PackBits decoder with RGB assembly and horizontal predictor undo.
// ----------------------------------------------------------------------------
// Usage:
//   strip : raw strip bytes, one item per byte; frame_start on the first byte
//           of an image clears all decoding state before that byte is used.
//   pixel : one item per decoded RGB pixel with its column, row, strip and
//           frame end flags; last_of_item marks the final pixel of a byte.
//   cfg   : cfg_we / cfg_index / cfg_data, written while the block is idle.
// Throughput: plain, literal and header bytes are taken back to back. The
//   data byte of a repeat run is latched, then gives n copies (2..128), one
//   decoded copy per cycle through the shared pixel assembly datapath while
//   the output is free. Bytes after image end are taken and dropped.
// Output: a pixel appears in the cycle after the byte step that completes it.
// Reset clears the run state, counters and the output register; registers
//   return to width 1, height 1, 8192 rows per strip, predictor and PackBits
//   off. A stalled output holds the strip input and emitting repeat steps.
// ----------------------------------------------------------------------------
module packbits_rgb_strip_pixel_decoder_unit #(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pbrgb_byte_if.sink                          strip,
    pbrgb_pixel_if.source                       pixel,
    input  logic                                cfg_we,
    input  logic [pbrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbrgb_pkg::CFG_W-1:0]         cfg_data
);

    pbrgb_pkg::cfg_t    cfg_reg;
    pbrgb_pkg::cmd_t    cmd;
    pbrgb_pkg::status_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_pixels  <= pbrgb_pkg::LINE_PIXELS_RST;
            cfg_reg.frame_lines  <= pbrgb_pkg::FRAME_LINES_RST;
            cfg_reg.strip_lines  <= pbrgb_pkg::STRIP_LINES_RST;
            cfg_reg.predictor_on <= 1'b0;
            cfg_reg.packbits_on  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbrgb_pkg::REG_LINE_PIXELS:  cfg_reg.line_pixels  <= cfg_data;
                pbrgb_pkg::REG_FRAME_LINES:  cfg_reg.frame_lines  <= cfg_data;
                pbrgb_pkg::REG_STRIP_LINES:  cfg_reg.strip_lines  <= cfg_data;
                pbrgb_pkg::REG_PREDICTOR_ON: cfg_reg.predictor_on <= cfg_data[0];
                pbrgb_pkg::REG_PACKBITS_ON:  cfg_reg.packbits_on  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    pbrgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (strip.valid),
        .in_ready (strip.ready),
        .st       (st),
        .cmd      (cmd)
    );

    pbrgb_datapath #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .st             (st),
        .in_byte        (strip.data_byte),
        .in_frame_start (strip.frame_start),
        .out_valid      (pixel.valid),
        .out_ready      (pixel.ready),
        .out_column     (pixel.pixel_column),
        .out_row        (pixel.pixel_row),
        .out_red        (pixel.red),
        .out_green      (pixel.green),
        .out_blue       (pixel.blue),
        .out_strip_end  (pixel.strip_end),
        .out_frame_end  (pixel.frame_end),
        .out_last       (pixel.last_of_item)
    );

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.rep_step))
        else $error("byte accept during repeat run");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rep_step && st.step_emits) |-> st.out_free)
        else $error("pixel step while output register is full");

    a_frame_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.frame_end) |-> (pixel.strip_end && pixel.last_of_item))
        else $error("frame end without strip end and item end");

endmodule

// ----- src/pbrgb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbrgb_ctrl
// Sequencer: takes bytes; repeat runs go one decoded byte per unstalled cycle.
// ----------------------------------------------------------------------------
module pbrgb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pbrgb_pkg::status_t st,
    output pbrgb_pkg::cmd_t    cmd
);

    pbrgb_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rep_step = 1'b0;
        state_next   = state_reg;
        case (state_reg)
            pbrgb_pkg::S_IDLE:
            begin
                in_ready   = st.out_free;
                cmd.accept = in_valid && st.out_free;
                if (cmd.accept && st.starts_repeat)
                begin
                    state_next = pbrgb_pkg::S_REPEAT;
                end
            end
            pbrgb_pkg::S_REPEAT:
            begin
                cmd.rep_step = !st.step_emits || st.out_free;
                if (cmd.rep_step && st.rep_final)
                begin
                    state_next = pbrgb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pbrgb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbrgb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/pbrgb_datapath.sv -----
// ----------------------------------------------------------------------------
// pbrgb_datapath
// PackBits run state, RGB assembly, predictor undo, raster counters and
// the output register.
// ----------------------------------------------------------------------------
module pbrgb_datapath #(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pbrgb_pkg::cfg_t    cfg,
    input  pbrgb_pkg::cmd_t    cmd,
    output pbrgb_pkg::status_t st,
    input  logic [7:0]         in_byte,
    input  logic               in_frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [12:0]        out_column,
    output logic [12:0]        out_row,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic               out_strip_end,
    output logic               out_frame_end,
    output logic               out_last
);

    localparam int CW   = $clog2(MAX_DIMENSION);
    localparam int DW   = $clog2(MAX_DIMENSION + 1);
    localparam int VW   = (DW > pbrgb_pkg::CFG_W) ? DW : pbrgb_pkg::CFG_W;
    localparam int CMPW = ((CW + 1) > VW) ? (CW + 1) : (VW + 1);

    pbrgb_pkg::run_mode_t mode_reg, mode_next, e_mode;
    logic [6:0]  lit_reg, lit_next, e_lit;
    logic [1:0]  phase_reg, phase_next, e_phase;
    logic [7:0]  hr_reg, hr_next, hg_reg, hg_next;
    logic [23:0] prev_reg, prev_next, e_prev;
    logic        havep_reg, havep_next, e_havep;
    logic [CW-1:0] col_reg, col_next, e_col;
    logic [CW-1:0] row_reg, row_next, e_row;
    logic [CW-1:0] strip_reg, strip_next, e_strip;
    logic        done_reg, done_next, e_done;
    logic [7:0]  rep_byte_reg, rep_byte_next;
    logic [7:0]  rep_left_reg, rep_left_next;

    logic        valid_reg, valid_next;
    logic [12:0] ocol_reg, orow_reg;
    logic [7:0]  ored_reg, ogreen_reg, oblue_reg;
    logic        ose_reg, ofe_reg, olast_reg;

    logic        clr, take_en, emit, strip_end_now, frame_end_now;
    logic [7:0]  tb, pr, pg, pb;
    logic [VW-1:0] w_ext, h_ext, s_ext, w_eff, h_eff, s_eff;
    logic [CW:0] col_inc, row_inc, strip_inc;

    assign clr = cmd.accept && in_frame_start;

    always_comb
    begin
        e_mode   = clr ? pbrgb_pkg::MODE_HEADER : mode_reg;
        e_lit    = clr ? 7'd0 : lit_reg;
        e_phase  = clr ? 2'd0 : phase_reg;
        e_prev   = clr ? 24'd0 : prev_reg;
        e_havep  = clr ? 1'b0 : havep_reg;
        e_col    = clr ? '0 : col_reg;
        e_row    = clr ? '0 : row_reg;
        e_strip  = clr ? '0 : strip_reg;
        e_done   = clr ? 1'b0 : done_reg;
    end

    always_comb
    begin
        w_ext = VW'(cfg.line_pixels);
        h_ext = VW'(cfg.frame_lines);
        s_ext = VW'(cfg.strip_lines);
        w_eff = (w_ext == '0) ? VW'(1) :
                (w_ext > VW'(MAX_DIMENSION)) ? VW'(MAX_DIMENSION) : w_ext;
        h_eff = (h_ext == '0) ? VW'(1) :
                (h_ext > VW'(MAX_DIMENSION)) ? VW'(MAX_DIMENSION) : h_ext;
        s_eff = (s_ext == '0) ? VW'(1) :
                (s_ext > VW'(MAX_DIMENSION)) ? VW'(MAX_DIMENSION) : s_ext;
    end

    assign tb      = cmd.rep_step ? rep_byte_reg : in_byte;
    assign take_en = !e_done && (cmd.rep_step ||
                     (cmd.accept && (!cfg.packbits_on || e_mode == pbrgb_pkg::MODE_LITERAL)));
    assign emit    = take_en && (e_phase == 2'd2);

    assign col_inc   = {1'b0, e_col} + 1'b1;
    assign row_inc   = {1'b0, e_row} + 1'b1;
    assign strip_inc = {1'b0, e_strip} + 1'b1;

    always_comb
    begin
        pr = hr_reg;
        pg = hg_reg;
        pb = tb;
        if (cfg.predictor_on && e_havep)
        begin
            pr = hr_reg + e_prev[23:16];
            pg = hg_reg + e_prev[15:8];
            pb = tb + e_prev[7:0];
        end
    end

    always_comb
    begin
        mode_next     = e_mode;
        lit_next      = e_lit;
        phase_next    = e_phase;
        hr_next       = hr_reg;
        hg_next       = hg_reg;
        prev_next     = e_prev;
        havep_next    = e_havep;
        col_next      = e_col;
        row_next      = e_row;
        strip_next    = e_strip;
        done_next     = e_done;
        rep_byte_next = rep_byte_reg;
        rep_left_next = rep_left_reg;
        strip_end_now = 1'b0;
        frame_end_now = 1'b0;

        if (take_en)
        begin
            case (e_phase)
                2'd0:
                begin
                    hr_next    = tb;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    hg_next    = tb;
                    phase_next = 2'd2;
                end
                default:
                begin
                    phase_next = 2'd0;
                    prev_next  = {pr, pg, pb};
                    havep_next = 1'b1;
                    col_next   = col_inc[CW-1:0];
                    if (CMPW'(col_inc) >= CMPW'(w_eff))
                    begin
                        col_next   = '0;
                        havep_next = 1'b0;
                        row_next   = row_inc[CW-1:0];
                        strip_next = strip_inc[CW-1:0];
                        if (CMPW'(row_inc) >= CMPW'(h_eff))
                        begin
                            strip_end_now = 1'b1;
                            frame_end_now = 1'b1;
                            done_next     = 1'b1;
                            strip_next    = '0;
                        end
                        else if (CMPW'(strip_inc) >= CMPW'(s_eff))
                        begin
                            strip_end_now = 1'b1;
                            strip_next    = '0;
                        end
                    end
                end
            endcase
        end

        if (cmd.accept && !e_done && cfg.packbits_on)
        begin
            case (e_mode)
                pbrgb_pkg::MODE_LITERAL:
                begin
                    if (e_lit == 7'd0)
                    begin
                        mode_next = pbrgb_pkg::MODE_HEADER;
                    end
                    else
                    begin
                        lit_next = e_lit - 7'd1;
                    end
                end
                pbrgb_pkg::MODE_REPEAT:
                begin
                    rep_byte_next = in_byte;
                    rep_left_next = {1'b0, e_lit} + 8'd1;
                    mode_next     = pbrgb_pkg::MODE_HEADER;
                    lit_next      = 7'd0;
                end
                default:
                begin
                    if (!in_byte[7])
                    begin
                        mode_next = pbrgb_pkg::MODE_LITERAL;
                        lit_next  = in_byte[6:0];
                    end
                    else if (in_byte != pbrgb_pkg::HDR_NOP)
                    begin
                        mode_next = pbrgb_pkg::MODE_REPEAT;
                        lit_next  = 7'(8'd0 - in_byte);
                    end
                end
            endcase
        end

        if (cmd.rep_step)
        begin
            rep_left_next = rep_left_reg - 8'd1;
        end
    end

    assign st.out_free      = !valid_reg || out_ready;
    assign st.starts_repeat = !e_done && cfg.packbits_on && (e_mode == pbrgb_pkg::MODE_REPEAT);
    assign st.step_emits    = !e_done && (e_phase == 2'd2);
    assign st.rep_final     = (rep_left_reg == 8'd1) || done_next;

    assign valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pbrgb_pkg::MODE_HEADER;
            lit_reg   <= 7'd0;
            phase_reg <= 2'd0;
            prev_reg  <= 24'd0;
            havep_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            strip_reg <= '0;
            done_reg  <= 1'b0;
            rep_left_reg <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            lit_reg   <= lit_next;
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            havep_reg <= havep_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            strip_reg <= strip_next;
            done_reg  <= done_next;
            rep_left_reg <= rep_left_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hr_reg       <= hr_next;
        hg_reg       <= hg_next;
        rep_byte_reg <= rep_byte_next;
        if (emit)
        begin
            ocol_reg   <= 13'(e_col);
            orow_reg   <= 13'(e_row);
            ored_reg   <= pr;
            ogreen_reg <= pg;
            oblue_reg  <= pb;
            ose_reg    <= strip_end_now;
            ofe_reg    <= frame_end_now;
            olast_reg  <= cmd.accept || (rep_left_reg <= 8'd3) || frame_end_now;
        end
    end

    assign out_valid     = valid_reg;
    assign out_column    = ocol_reg;
    assign out_row       = orow_reg;
    assign out_red       = ored_reg;
    assign out_green     = ogreen_reg;
    assign out_blue      = oblue_reg;
    assign out_strip_end = ose_reg;
    assign out_frame_end = ofe_reg;
    assign out_last      = olast_reg;

endmodule
